// ===== hdl/tcnbh_pkg.sv =====
// tcnbh_pkg: shared types, widths and register codes for the three channel
// nearest bin histogram. no dependencies.
package tcnbh_pkg;

  localparam int NUM_LANES     = 3;
  localparam int LANE_W        = 2;
  localparam int SAMPLE_W      = 16;
  localparam int NUM_W         = 17;
  localparam int STEP_W        = 15;
  localparam int BINS_CFG_W    = 11;
  localparam int FRAME_W       = 16;
  localparam int BIN_OUT_W     = 10;
  localparam int READ_COUNT_W  = 16;
  localparam int READ_CH_W     = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam int MAX_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CHANNELS_DEF    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_LOW     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_STEP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BINS_IN_USE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES      = 2'd3;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] BIN_LOW_RST     = -16'sd15139;
  localparam logic [STEP_W-1:0]          BIN_STEP_RST    = 15'd33;
  localparam logic [BINS_CFG_W-1:0]      BINS_IN_USE_RST = 11'd925;
  localparam logic [FRAME_W-1:0]         FRAMES_RST      = 16'd100;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic signed [SAMPLE_W-1:0] sample_c;
    logic [READ_CH_W-1:0]       read_channel;
    logic [BIN_OUT_W-1:0]       read_bin;
  } in_beat_t;

  typedef struct packed {
    logic                    complete;
    logic [READ_COUNT_W-1:0] read_count;
    logic [BIN_OUT_W-1:0]    bin_a;
    logic [BIN_OUT_W-1:0]    bin_b;
    logic [BIN_OUT_W-1:0]    bin_c;
  } out_beat_t;

endpackage

// ===== hdl/tcnbh_div.sv =====
// tcnbh_div: restoring divider, one quotient bit per cycle, all lanes in
// parallel over a shared divisor. depends on tcnbh_pkg.
module tcnbh_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tcnbh_pkg::NUM_W-1:0]       num_in [tcnbh_pkg::NUM_LANES],
  input  logic [tcnbh_pkg::STEP_W-1:0]      den_in,
  output logic                              done,
  output logic [tcnbh_pkg::NUM_W-1:0]       quot [tcnbh_pkg::NUM_LANES]
);

  localparam int NW    = tcnbh_pkg::NUM_W;
  localparam int SW    = tcnbh_pkg::STEP_W;
  localparam int L     = tcnbh_pkg::NUM_LANES;
  localparam int CNT_W = $clog2(NW);

  logic            busy_r;
  logic            done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SW-1:0]   den_r;
  logic [SW-1:0]   rem_r [L];
  logic [NW-1:0]   quo_r [L];
  logic [SW-1:0]   rem_nxt [L];
  logic [NW-1:0]   quo_nxt [L];

  always_comb begin
    logic [SW:0] trial;
    for (int i = 0; i < L; i++) begin
      trial = {rem_r[i], quo_r[i][NW-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt[i] = SW'(trial - {1'b0, den_r});
        quo_nxt[i] = {quo_r[i][NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[SW-1:0];
        quo_nxt[i] = {quo_r[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= (den_in == '0) ? SW'(1) : den_in;
      for (int i = 0; i < L; i++) begin
        rem_r[i] <= '0;
        quo_r[i] <= num_in[i];
      end
    end else if (busy_r) begin
      for (int i = 0; i < L; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hdl/three_channel_nearest_bin_histogram.sv =====
// three_channel_nearest_bin_histogram: top level, count memory, control and
// configuration registers. depends on tcnbh_pkg and tcnbh_div.
//
// usage:
//   input channel in_valid/in_ready/in_data carries one beat per item: an add
//   beat (kind 0) with one sample per channel, or a read beat (kind 1) that
//   names a channel and a bin. every item gives exactly one result beat on
//   out_valid/out_ready/out_data, in order.
//   an add beat's result passes through the bit-serial divider (all channels
//   at once); its quotients are clamped to the last bin in use as it ends,
//   then a read and a write-back step per channel on the single count
//   memory, then the output register is loaded. a read beat's count is read
//   from the memory as it is accepted, then loaded into the output register.
//   one item is worked on at a time and in_ready rises as the result is loaded.
//   after reset the count memory is cleared one entry per cycle, CHANNELS
//   times 2^clog2(MAX_BINS) entries (3072 at the defaults), with in_ready low.
//   configuration writes on cfg_we/cfg_index/cfg_wdata belong between items.
//   if the receiver stalls, the result waits in the output register; the
//   next item may be accepted and worked but its result waits for the first.
module three_channel_nearest_bin_histogram #(
  parameter int MAX_BINS    = tcnbh_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = tcnbh_pkg::COUNT_WIDTH_DEF,
  parameter int CHANNELS    = tcnbh_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcnbh_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcnbh_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic [tcnbh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcnbh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int L         = tcnbh_pkg::NUM_LANES;
  localparam int LW        = tcnbh_pkg::LANE_W;
  localparam int NW        = tcnbh_pkg::NUM_W;
  localparam int SW        = tcnbh_pkg::SAMPLE_W;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS << BIN_W;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ACT_CH    = (CHANNELS < L) ? CHANNELS : L;
  localparam int FW        = tcnbh_pkg::FRAME_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // configuration
  logic signed [SW-1:0]                    bin_low_r;
  logic [tcnbh_pkg::STEP_W-1:0]            bin_step_r;
  logic [tcnbh_pkg::BINS_CFG_W-1:0]        bins_in_use_r;
  logic [FW-1:0]                           frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_low_r     <= tcnbh_pkg::BIN_LOW_RST;
      bin_step_r    <= tcnbh_pkg::BIN_STEP_RST;
      bins_in_use_r <= tcnbh_pkg::BINS_IN_USE_RST;
      frames_r      <= tcnbh_pkg::FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcnbh_pkg::CFG_BIN_LOW:     bin_low_r     <= cfg_wdata;
        tcnbh_pkg::CFG_BIN_STEP:    bin_step_r    <= cfg_wdata[tcnbh_pkg::STEP_W-1:0];
        tcnbh_pkg::CFG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[tcnbh_pkg::BINS_CFG_W-1:0];
        tcnbh_pkg::CFG_FRAMES:      frames_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic                kind_r;
  logic                rd_ok_r;
  logic [LW-1:0]       ch_r;
  logic [BIN_W-1:0]    bins_r [L];
  logic [FW-1:0]       frame_cnt_r;
  logic                complete_r;
  logic                out_valid_r;
  tcnbh_pkg::out_beat_t out_data_r;

  // count memory
  logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   mem_re, mem_we;
  logic [ADDR_W-1:0]      mem_raddr, mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // divider
  logic              div_start;
  logic              div_done;
  logic [NW-1:0]     div_num [L];
  logic [NW-1:0]     div_quot [L];
  logic signed [SW-1:0] samples [L];

  assign samples[0] = in_data.sample_a;
  assign samples[1] = in_data.sample_b;
  assign samples[2] = in_data.sample_c;

  always_comb begin
    logic signed [NW:0] num_s;
    for (int i = 0; i < L; i++) begin
      num_s = (NW+1)'(samples[i]) - (NW+1)'(bin_low_r)
            + $signed({3'b000, bin_step_r[tcnbh_pkg::STEP_W-1:1]});
      div_num[i] = num_s[NW] ? '0 : num_s[NW-1:0];
    end
  end

  tcnbh_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_in (div_num),
    .den_in (bin_step_r),
    .done   (div_done),
    .quot   (div_quot)
  );

  // last bin in use
  logic [NW-1:0] last_m1;
  logic [NW-1:0] last_bin;

  always_comb begin
    last_m1  = (bins_in_use_r == '0) ? '0 : NW'(bins_in_use_r) - NW'(1);
    last_bin = (last_m1 > NW'(MAX_BINS - 1)) ? NW'(MAX_BINS - 1) : last_m1;
  end

  // handshakes and item decode
  logic accept;
  logic rd_ok;
  logic out_free;
  logic [ADDR_W-1:0] lane_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [FW-1:0] frame_inc;
  logic complete_new;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign rd_ok     = (32'(in_data.read_channel) < CHANNELS) &&
                     (32'(in_data.read_bin) < MAX_BINS);
  assign read_addr = ADDR_W'({CH_W'(in_data.read_channel), BIN_W'(in_data.read_bin)});
  assign lane_addr = ADDR_W'({CH_W'(ch_r), bins_r[ch_r]});
  assign count_inc = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  assign frame_inc = (frame_cnt_r == '1) ? frame_cnt_r : frame_cnt_r + 1'b1;
  assign complete_new = complete_r || (frame_inc >= frames_r);
  assign div_start = accept && (in_data.kind == tcnbh_pkg::KIND_ADD);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = lane_addr;
    mem_we    = 1'b0;
    mem_waddr = lane_addr;
    mem_wdata = count_inc;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind == tcnbh_pkg::KIND_READ) begin
            mem_re    = rd_ok;
            mem_raddr = read_addr;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_RD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we    = 1'b1;
        state_nxt = (ch_r == LW'(ACT_CH - 1)) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      frame_cnt_r <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == S_DIV) ch_r <= '0;
      if (state_r == S_WR) ch_r <= ch_r + 1'b1;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (kind_r == tcnbh_pkg::KIND_ADD) begin
          frame_cnt_r <= frame_inc;
          complete_r  <= complete_new;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_data.kind;
      rd_ok_r <= rd_ok;
    end
    if (state_r == S_DIV && div_done) begin
      for (int i = 0; i < L; i++) begin
        bins_r[i] <= (div_quot[i] > last_bin) ? BIN_W'(last_bin) : BIN_W'(div_quot[i]);
      end
    end
    if (state_r == S_FIN && out_free) begin
      if (kind_r == tcnbh_pkg::KIND_READ) begin
        out_data_r.complete   <= complete_r;
        out_data_r.read_count <= rd_ok_r ? tcnbh_pkg::READ_COUNT_W'(rd_data_r) : '0;
        out_data_r.bin_a      <= '0;
        out_data_r.bin_b      <= '0;
        out_data_r.bin_c      <= '0;
      end else begin
        out_data_r.complete   <= complete_new;
        out_data_r.read_count <= '0;
        out_data_r.bin_a      <= (CHANNELS > 0) ? tcnbh_pkg::BIN_OUT_W'(bins_r[0]) : '0;
        out_data_r.bin_b      <= (CHANNELS > 1) ? tcnbh_pkg::BIN_OUT_W'(bins_r[1]) : '0;
        out_data_r.bin_c      <= (CHANNELS > 2) ? tcnbh_pkg::BIN_OUT_W'(bins_r[2]) : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
